// ===== rtl/core/tcq_pkg.sv =====
// Shared types, widths and codes for the timed command queue.
// Depends on nothing; every other file of the block imports it.
package tcq_pkg;

    // Default ring depth; one slot always stays unused.
    localparam int TCQ_QUEUE_SLOTS = 128;

    // Field widths fixed by the transaction format.
    localparam int REQ_W    = 2;
    localparam int CMD_W    = 8;
    localparam int TICKS_W  = 15;
    localparam int STEP_W   = 8;
    localparam int STATUS_W = 3;

    // Request codes.
    typedef enum logic [REQ_W-1:0] {
        REQ_PUSH    = 2'd0,
        REQ_TICK    = 2'd1,
        REQ_RELEASE = 2'd2
    } req_code_t;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        ST_IDLE    = 3'd0,
        ST_SENT    = 3'd1,
        ST_BLOCKED = 3'd2,
        ST_PUSHED  = 3'd3,
        ST_FULL    = 3'd4
    } status_t;

    // One stored queue entry.
    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        logic [TICKS_W-1:0] wait_cnt;
        logic [TICKS_W-1:0] hold_cnt;
    } slot_t;

    // One request transaction as held in the input register.
    typedef struct packed {
        logic [REQ_W-1:0]  req_type;
        slot_t             slot;
        logic [STEP_W-1:0] ticks;
    } item_t;

    // One result transaction.
    typedef struct packed {
        status_t          status;
        logic [CMD_W-1:0] sent_byte;
    } result_t;

    // Countdown that stops at zero.
    function automatic logic [TICKS_W-1:0] sat_sub(input logic [TICKS_W-1:0] a,
                                                   input logic [STEP_W-1:0]  b);
        logic [TICKS_W-1:0] b_ext;
        b_ext = {{(TICKS_W-STEP_W){1'b0}}, b};
        return (a > b_ext) ? (a - b_ext) : '0;
    endfunction

endpackage

// ===== rtl/core/tcq_req_if.sv =====
// Request channel of the timed command queue: valid/ready plus payload.
// Depends on tcq_pkg for the field widths.
interface tcq_req_if;
    import tcq_pkg::*;

    logic                valid;
    logic                ready;
    logic [REQ_W-1:0]    req_type;
    logic [CMD_W-1:0]    cmd_byte;
    logic [TICKS_W-1:0]  wait_ticks;
    logic [TICKS_W-1:0]  hold_ticks;
    logic [STEP_W-1:0]   ticks_passed;

    modport source (
        output valid, req_type, cmd_byte, wait_ticks, hold_ticks, ticks_passed,
        input  ready
    );

    modport sink (
        input  valid, req_type, cmd_byte, wait_ticks, hold_ticks, ticks_passed,
        output ready
    );
endinterface

// ===== rtl/core/tcq_rsp_if.sv =====
// Result channel of the timed command queue: valid/ready plus payload.
// Depends on tcq_pkg for the field widths.
interface tcq_rsp_if;
    import tcq_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [CMD_W-1:0]    sent_byte;

    modport source (
        output valid, status, sent_byte,
        input  ready
    );

    modport sink (
        input  valid, status, sent_byte,
        output ready
    );
endinterface

// ===== rtl/core/timed_command_queue_core.sv =====
// Timed command queue: the input register, a single pass of event logic
// with a registered slot-memory read and the result register lie between
// request and result; one transaction per cycle sustained while the
// result side does not stall. Asynchronous active-low reset empties the
// queue and clears the running hold; slot contents are not reset.
module timed_command_queue_core #(
    parameter int QUEUE_SLOTS = tcq_pkg::TCQ_QUEUE_SLOTS
) (
    input logic   clk,
    input logic   rst_n,
    tcq_req_if.sink   req,
    tcq_rsp_if.source rsp
);
    import tcq_pkg::*;

    logic    in_valid_reg;
    item_t   in_item_reg;
    logic    out_valid_reg;
    result_t out_res_reg;
    logic    advance;
    result_t step_res;

    // The input register moves on whenever the result register is free.
    assign advance   = in_valid_reg && (!out_valid_reg || rsp.ready);
    assign req.ready = !in_valid_reg || advance;

    // Handshake state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (req.valid && req.ready)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            in_item_reg.req_type      <= req.req_type;
            in_item_reg.slot.cmd      <= req.cmd_byte;
            in_item_reg.slot.wait_cnt <= req.wait_ticks;
            in_item_reg.slot.hold_cnt <= req.hold_ticks;
            in_item_reg.ticks         <= req.ticks_passed;
        end
        if (advance)
        begin
            out_res_reg <= step_res;
        end
    end

    tcq_sched #(
        .QUEUE_SLOTS (QUEUE_SLOTS)
    ) u_sched (
        .clk    (clk),
        .rst_n  (rst_n),
        .go     (advance),
        .item   (in_item_reg),
        .result (step_res)
    );

    assign rsp.valid     = out_valid_reg;
    assign rsp.status    = out_res_reg.status;
    assign rsp.sent_byte = out_res_reg.sent_byte;

`ifndef SYNTH
    // Only a sent command carries a byte.
    a_byte_only_when_sent: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && (rsp.status != ST_SENT)) |-> (rsp.sent_byte == '0))
        else $error("sent_byte nonzero on a result that sent nothing");

    // A processed transaction shows up as a result on the next cycle.
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> rsp.valid)
        else $error("processed transaction produced no result");

    // A held request is not dropped while the result side stalls.
    a_request_kept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && rsp.valid && !rsp.ready) |=> in_valid_reg)
        else $error("pending request lost during a result stall");
`endif
endmodule

// ===== rtl/core/tcq_slot_ram.sv =====
// Slot memory of the queue: one write port, one read port with registered data.
// A write to the address being read is forwarded into the read register.
// Depends on tcq_pkg for the slot type.
module tcq_slot_ram #(
    parameter int  DEPTH  = tcq_pkg::TCQ_QUEUE_SLOTS,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic                clk,
    input  logic                we,
    input  logic [ADDR_W-1:0]   waddr,
    input  tcq_pkg::slot_t      wdata,
    input  logic [ADDR_W-1:0]   raddr,
    output tcq_pkg::slot_t      rdata
);
    import tcq_pkg::*;

    slot_t mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read with write-through forwarding.
    always_ff @(posedge clk)
    begin
        if (we && (waddr == raddr))
        begin
            rdata <= wdata;
        end
        else
        begin
            rdata <= mem[raddr];
        end
    end
endmodule

// ===== rtl/core/tcq_sched.sv =====
// Queue state and per-transaction event logic: pointers, running hold and the
// head entry kept in registers, with the entry after the head prefetched.
// Depends on tcq_pkg and tcq_slot_ram.
module tcq_sched #(
    parameter int  QUEUE_SLOTS = tcq_pkg::TCQ_QUEUE_SLOTS,
    localparam int PTR_W       = $clog2(QUEUE_SLOTS)
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             go,
    input  tcq_pkg::item_t   item,
    output tcq_pkg::result_t result
);
    import tcq_pkg::*;

    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [TICKS_W-1:0] hold_left_reg, hold_left_next;
    slot_t              head_reg, head_next;

    logic               ram_we;
    logic [PTR_W-1:0]   ram_raddr;
    slot_t              ram_rdata;

    logic               empty;
    logic               full;
    logic [TICKS_W-1:0] hold_dec;
    logic [TICKS_W-1:0] wait_dec;

    // Ring pointer advance with wrap at the last slot.
    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(QUEUE_SLOTS - 1)) ? '0 : p + 1'b1;
    endfunction

    assign empty    = (rd_ptr_reg == wr_ptr_reg);
    assign full     = (ptr_inc(wr_ptr_reg) == rd_ptr_reg);
    assign hold_dec = sat_sub(hold_left_reg, item.ticks);
    assign wait_dec = sat_sub(head_reg.wait_cnt, item.ticks);

    // Event decode and next-state logic.
    always_comb
    begin
        wr_ptr_next    = wr_ptr_reg;
        rd_ptr_next    = rd_ptr_reg;
        hold_left_next = hold_left_reg;
        head_next      = head_reg;
        ram_we         = 1'b0;
        result         = '{status: ST_IDLE, sent_byte: '0};
        if (go)
        begin
            case (req_code_t'(item.req_type))
                REQ_PUSH:
                begin
                    if (!full)
                    begin
                        ram_we        = 1'b1;
                        wr_ptr_next   = ptr_inc(wr_ptr_reg);
                        result.status = ST_PUSHED;
                        if (empty)
                        begin
                            head_next = item.slot;
                        end
                    end
                    else
                    begin
                        result.status = ST_FULL;
                    end
                end
                REQ_TICK:
                begin
                    if (hold_left_reg != '0)
                    begin
                        hold_left_next = hold_dec;
                    end
                    if ((hold_left_reg != '0) && (hold_dec != '0))
                    begin
                        result.status = ST_BLOCKED;
                    end
                    else if (!empty)
                    begin
                        head_next.wait_cnt = wait_dec;
                        if (wait_dec == '0)
                        begin
                            // Send the head and promote the prefetched entry.
                            hold_left_next   = head_reg.hold_cnt;
                            result.sent_byte = head_reg.cmd;
                            result.status    = ST_SENT;
                            rd_ptr_next      = ptr_inc(rd_ptr_reg);
                            head_next        = ram_rdata;
                        end
                    end
                end
                REQ_RELEASE:
                begin
                    hold_left_next = '0;
                end
                default:
                begin
                    result.status = ST_IDLE;
                end
            endcase
        end
    end

    // Keep the read register on the slot after the head.
    assign ram_raddr = ptr_inc(rd_ptr_next);

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg    <= '0;
            rd_ptr_reg    <= '0;
            hold_left_reg <= '0;
        end
        else
        begin
            wr_ptr_reg    <= wr_ptr_next;
            rd_ptr_reg    <= rd_ptr_next;
            hold_left_reg <= hold_left_next;
        end
    end

    // Head entry payload.
    always_ff @(posedge clk)
    begin
        head_reg <= head_next;
    end

    tcq_slot_ram #(
        .DEPTH (QUEUE_SLOTS)
    ) u_slot_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wr_ptr_reg),
        .wdata (item.slot),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );
endmodule
